[hdl/sib_pkg.sv]
// ----------------------------------------------------------------------------
// Snapshot interpolation buffer package
// Shared constants and payload types.
// ----------------------------------------------------------------------------
package sib_pkg;

  localparam int unsigned BufferDepth = 64;
  localparam int unsigned IdxW        = $clog2(BufferDepth);
  localparam int unsigned CntW        = $clog2(BufferDepth + 1);
  localparam int unsigned RecW        = 224;
  localparam int unsigned ClkW        = 44;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 31;

  localparam logic [CfgIdxW-1:0] RegDelay     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSnap      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSyncVel   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegAuthority = 2'd3;

  localparam logic CmdPush = 1'b0;
  localparam logic CmdTick = 1'b1;

  localparam logic signed [ClkW-1:0] ResyncDriftUs = 44'sd500000;

  typedef struct packed {
    logic               command;
    logic [31:0]        sample_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] rotation;
    logic signed [31:0] lin_vel_x;
    logic signed [31:0] lin_vel_y;
    logic signed [31:0] ang_vel;
    logic [19:0]        tick_delta_us;
  } sib_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_rotation;
    logic signed [31:0] out_lin_vel_x;
    logic signed [31:0] out_lin_vel_y;
    logic signed [31:0] out_ang_vel;
    logic               velocity_valid;
  } sib_out_t;

endpackage

[hdl/sib_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sib_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hdl/snapshot_interpolation_buffer_top.sv]
// ----------------------------------------------------------------------------
// Snapshot interpolation buffer
// Ring of timestamped pose samples with a render clock and lerped output.
// ----------------------------------------------------------------------------
// Push: busy while it reads the newest record, then compares and writes. Tick:
// the result comes from a serial RAM scan of K <= N samples, a restoring fraction
// divider and one shared 33x18 multiplier used for four snap and six lerp products.
// Each pop then takes a read state and a check state. The result waits in an output
// register while the next request is accepted.
// Reset clears ring pointers and render clock, sets config to defaults; RAM is not cleared.
module snapshot_interpolation_buffer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  sib_pkg::sib_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sib_pkg::sib_out_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [sib_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sib_pkg::CfgDataW-1:0] cfg_data_i
);
  import sib_pkg::*;

  typedef enum logic [13:0] {
    StIdle   = 14'b00000000000001,
    StPushRd = 14'b00000000000010,
    StPushCk = 14'b00000000000100,
    StTickRd = 14'b00000000001000,
    StClock  = 14'b00000000010000,
    StScanRd = 14'b00000000100000,
    StScanCk = 14'b00000001000000,
    StDiv    = 14'b00000010000000,
    StSnapMul= 14'b00000100000000,
    StSnapCk = 14'b00001000000000,
    StLerp   = 14'b00010000000000,
    StEmit   = 14'b00100000000000,
    StPopRd  = 14'b01000000000000,
    StPopCk  = 14'b10000000000000
  } state_e;

  state_e state_q;

  logic [15:0] delay_q;
  logic [30:0] snap_q;
  logic        syncv_q, auth_q;

  logic [IdxW-1:0] oldest_q;
  logic [CntW-1:0] count_q;
  logic signed [ClkW-1:0] rclk_q;
  logic        interp_q;

  sib_in_t req_q;
  logic [RecW-1:0] a_q, b_q;         // bracketing records
  logic [CntW-1:0] k_q;              // scan position
  logic [1:0]      sub_q;            // clock step phase
  logic [ClkW-1:0] rem_q;            // divider remainder
  logic [ClkW-1:0] den_q;
  logic [16:0]     quo_q;
  logic [ClkW-1:0] num_q;
  logic [4:0]      div_cnt_q;
  logic [16:0]     t_q;
  logic [2:0]      lane_q;
  logic [64:0]     sq_q;             // sum of squares, one spare bit
  logic [1:0]      mph_q;            // snap multiply phase
  logic signed [31:0] res_q [6];
  logic            out_valid_q;
  sib_out_t        out_q;

  // RAM
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [RecW-1:0] ram_wdata, ram_rdata;

  sib_ram #(.Width(RecW), .Depth(BufferDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  function automatic logic [IdxW-1:0] slot_of(logic [IdxW-1:0] o, logic [CntW-1:0] k);
    logic [CntW:0] s;
    s = {1'b0, CntW'(o)} + {1'b0, k};
    if (s >= (CntW+1)'(BufferDepth)) begin
      s = s - (CntW+1)'(BufferDepth);
    end
    return s[IdxW-1:0];
  endfunction

  function automatic logic signed [ClkW-1:0] ms_to_us(logic [31:0] ms);
    return ClkW'({ms, 10'd0}) - ClkW'({ms, 4'd0}) - ClkW'({ms, 3'd0});
  endfunction

  function automatic logic signed [31:0] fld(logic [RecW-1:0] r, logic [2:0] i);
    return r[32*(5-i) +: 32];
  endfunction

  logic [31:0] a_time, b_time, rd_time;
  assign a_time  = a_q[RecW-1 -: 32];
  assign b_time  = b_q[RecW-1 -: 32];
  assign rd_time = ram_rdata[RecW-1 -: 32];

  logic signed [ClkW-1:0] a_us, b_us, rd_us, target_us, latest_us;
  assign a_us  = ms_to_us(a_time);
  assign b_us  = ms_to_us(b_time);
  assign rd_us = ms_to_us(rd_time);
  assign latest_us = b_us;  // b_q holds newest during clock step
  assign target_us = latest_us - ms_to_us({16'd0, delay_q});

  logic signed [ClkW-1:0] rclk_step;
  assign rclk_step = rclk_q + $signed(ClkW'(req_q.tick_delta_us));

  logic [RecW-1:0] push_rec;
  assign push_rec = {req_q.sample_time, req_q.pos_x, req_q.pos_y, req_q.rotation,
                     req_q.lin_vel_x, req_q.lin_vel_y, req_q.ang_vel};

  // shared multiplier: 33-bit signed x 18-bit signed
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;
  logic signed [32:0] dlane;
  assign dlane = 33'(fld(b_q, lane_q)) - 33'(fld(a_q, lane_q));
  assign mul_p = mul_a * mul_b;

  // snap: |d| squared from its 17-bit low and 16-bit high parts: d^2 = d*dl + (d*dh)<<17
  logic [32:0] absd;
  assign absd = dlane[32] ? 33'(-dlane) : dlane;

  always_comb begin
    mul_a = dlane;
    mul_b = $signed({1'b0, t_q});
    if (state_q == StSnapMul) begin
      mul_a = $signed(absd);
      mul_b = mph_q[0] ? $signed({2'b0, absd[32:17]}) : $signed({1'b0, absd[16:0]});
    end
  end

  logic signed [31:0] lerp_res;
  logic signed [50:0] flr;
  assign flr = mul_p >>> 16;
  assign lerp_res = 32'(fld(a_q, lane_q) + 32'(flr));

  logic [63:0] thr_sq;
  assign thr_sq = 64'(snap_q) * 64'(snap_q);

  logic in_acc;
  logic out_load;
  assign in_ready_o = (state_q == StIdle);
  assign in_acc = in_valid_i && in_ready_o;
  // hold in emit until the output register is free
  assign out_load = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_of(oldest_q, count_q);
    ram_wdata = push_rec;
    ram_raddr = slot_of(oldest_q, count_q - 1'b1);
    case (state_q)
      StScanRd: ram_raddr = slot_of(oldest_q, k_q);
      StPopRd:  ram_raddr = slot_of(oldest_q, CntW'(1));
      default: ;
    endcase
    if (state_q == StPushCk) begin
      if (count_q != '0 && req_q.sample_time == rd_time) begin
        ram_we = 1'b1;
        ram_waddr = slot_of(oldest_q, count_q - 1'b1);
      end else if (count_q == '0 || req_q.sample_time > rd_time) begin
        ram_we = 1'b1;
        ram_waddr = (count_q == CntW'(BufferDepth)) ? oldest_q : slot_of(oldest_q, count_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      delay_q <= 16'd100;
      snap_q <= '0;
      syncv_q <= 1'b1;
      auth_q <= 1'b0;
      oldest_q <= '0;
      count_q <= '0;
      rclk_q <= '0;
      interp_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDelay:     delay_q <= cfg_data_i[15:0];
          RegSnap:      snap_q  <= cfg_data_i;
          RegSyncVel:   syncv_q <= cfg_data_i[0];
          RegAuthority: auth_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            req_q <= in_data_i;
            state_q <= (in_data_i.command == CmdPush) ? StPushRd : StTickRd;
          end
        end
        StPushRd: state_q <= StPushCk;
        StPushCk: begin
          if (count_q == '0 || req_q.sample_time > rd_time) begin
            if (count_q == CntW'(BufferDepth)) begin
              oldest_q <= slot_of(oldest_q, CntW'(1));
            end else begin
              count_q <= count_q + 1'b1;
            end
          end
          state_q <= StIdle;
        end
        StTickRd: begin
          sub_q <= '0;
          if (auth_q) begin
            oldest_q <= '0;
            count_q <= '0;
            interp_q <= 1'b0;
            state_q <= StIdle;
          end else if (count_q == '0) begin
            state_q <= StIdle;
          end else begin
            state_q <= StClock;
          end
        end
        StClock: begin
          // phase 0 latch newest; 1 init or advance/clamp; 2 resync; 3 start scan
          case (sub_q)
            2'd0: begin
              b_q <= ram_rdata;
              sub_q <= 2'd1;
            end
            2'd1: begin
              if (!interp_q) begin
                rclk_q <= target_us;
                interp_q <= 1'b1;
              end else if (rclk_step > latest_us) begin
                rclk_q <= latest_us;
              end else begin
                rclk_q <= rclk_step;
              end
              sub_q <= 2'd2;
            end
            2'd2: begin
              if (rclk_q < target_us - ResyncDriftUs) rclk_q <= target_us;
              sub_q <= 2'd3;
            end
            default: begin
              k_q <= '0;
              state_q <= StScanRd;
            end
          endcase
        end
        StScanRd: state_q <= StScanCk;
        StScanCk: begin
          // a_q trails as previous record; k_q is index of ram_rdata
          if (k_q == '0) begin
            if (rclk_q <= rd_us) begin
              a_q <= ram_rdata;
              b_q <= ram_rdata;
              state_q <= StDiv;
            end else if (rclk_q >= latest_us) begin
              a_q <= b_q;
              state_q <= StDiv;
            end else begin
              a_q <= ram_rdata;
              k_q <= k_q + 1'b1;
              state_q <= StScanRd;
            end
          end else if (rclk_q <= rd_us) begin
            b_q <= ram_rdata;
            state_q <= StDiv;
          end else begin
            a_q <= ram_rdata;
            k_q <= k_q + 1'b1;
            state_q <= StScanRd;
          end
          num_q <= rclk_q - a_us;
          div_cnt_q <= '0;
          quo_q <= '0;
          rem_q <= '0;
        end
        StDiv: begin
          // load, then 16 restoring steps of (num<<16) / den; num >= den clamps
          if (div_cnt_q == '0) begin
            num_q <= rclk_q - a_us;
            den_q <= b_us - a_us;
            rem_q <= '0;
            div_cnt_q <= 5'd1;
          end else if (div_cnt_q <= 5'd17) begin
            if (b_us <= a_us || num_q[ClkW-1] || num_q == '0) begin
              div_cnt_q <= 5'd18;
            end else if (num_q >= den_q) begin
              quo_q <= 17'h10000;  // clamp
              div_cnt_q <= 5'd18;
            end else begin
              if (div_cnt_q == 5'd1) begin
                rem_q <= num_q;
              end else if ({rem_q[ClkW-2:0], 1'b0} >= den_q) begin
                rem_q <= {rem_q[ClkW-2:0], 1'b0} - den_q;
                quo_q <= {quo_q[15:0], 1'b1};
              end else begin
                rem_q <= {rem_q[ClkW-2:0], 1'b0};
                quo_q <= {quo_q[15:0], 1'b0};
              end
              div_cnt_q <= div_cnt_q + 1'b1;
            end
          end else begin
            t_q <= (b_us > a_us) ? quo_q : 17'd0;
            lane_q <= '0;
            mph_q <= '0;
            sq_q <= '0;
            state_q <= (snap_q != '0) ? StSnapMul : StLerp;
          end
        end
        StSnapMul: begin
          mph_q <= mph_q + 1'b1;
          if (mph_q[0]) sq_q <= sq_q + ({14'd0, mul_p} << 17);
          else sq_q <= sq_q + {14'd0, mul_p};
          if (mph_q == 2'd1) lane_q <= 3'd1;
          if (mph_q == 2'd3) state_q <= StSnapCk;
        end
        StSnapCk: begin
          if (sq_q > 65'(thr_sq)) t_q <= 17'h10000;
          lane_q <= '0;
          state_q <= StLerp;
        end
        StLerp: begin
          res_q[lane_q] <= lerp_res;
          if (lane_q == 3'd5) state_q <= StEmit;
          else lane_q <= lane_q + 1'b1;
        end
        StEmit: begin
          if (out_load) begin
            out_q.out_pos_x <= res_q[0];
            out_q.out_pos_y <= res_q[1];
            out_q.out_rotation <= res_q[2];
            out_q.out_lin_vel_x <= syncv_q ? res_q[3] : '0;
            out_q.out_lin_vel_y <= syncv_q ? res_q[4] : '0;
            out_q.out_ang_vel <= syncv_q ? res_q[5] : '0;
            out_q.velocity_valid <= syncv_q;
            state_q <= StPopRd;
          end
        end
        StPopRd: state_q <= (count_q > CntW'(2)) ? StPopCk : StIdle;
        StPopCk: begin
          if (rd_us <= rclk_q) begin
            oldest_q <= slot_of(oldest_q, CntW'(1));
            count_q <= count_q - 1'b1;
            state_q <= StPopRd;
          end else begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

[hdl/sib_checker.sv]
// ----------------------------------------------------------------------------
// Snapshot interpolation buffer checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
module sib_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input sib_pkg::sib_out_t out_data_o
);
  import sib_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after request");

  a_vel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.velocity_valid |->
      out_data_o.out_lin_vel_x == '0 && out_data_o.out_ang_vel == '0)
    else $error("velocity not cleared");
endmodule

bind snapshot_interpolation_buffer_top sib_checker u_sib_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

[dv/snapshot_interpolation_buffer_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Snapshot interpolation buffer testbench
// Drives push and tick requests under random idling and back-pressure.
// A behavioral model of the ring and render clock predicts every pose, and
// a scoreboard compares each whole result with it, in order.
// ----------------------------------------------------------------------------
module snapshot_interpolation_buffer_top_tb;
  import sib_pkg::*;

  localparam int Depth = 64;
  localparam int WatchdogLimit = 20000;

  typedef struct {
    logic [31:0]        tms;
    logic signed [31:0] v[6];
  } pose_rec_t;

  class pose_scoreboard;
    sib_out_t pending_poses[$];
    int       mismatches;
    int       oldest, count;
    longint   render_us;
    bit       running;
    pose_rec_t ring[Depth];
    logic [15:0] delay_ms;
    logic [30:0] snap_th;
    bit       sync_vel, authority;

    function void clear_all();
      oldest = 0; count = 0; render_us = 0; running = 0;
      delay_ms = 100; snap_th = 0; sync_vel = 1; authority = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        RegDelay:     delay_ms = d[15:0];
        RegSnap:      snap_th = d[30:0];
        RegSyncVel:   sync_vel = d[0];
        RegAuthority: authority = d[0];
        default: ;
      endcase
    endfunction

    function int at(int k);
      return (oldest + k) % Depth;
    endfunction

    function logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                       longint t);
      longint p;
      longint f;
      p = (longint'(b) - longint'(a)) * t;
      f = p >>> 16;
      return 32'(longint'(a) + f);
    endfunction

    function bit too_far(pose_rec_t a, pose_rec_t b);
      longint unsigned dx, dy, sx, s, th;
      longint d;
      d = longint'(b.v[0]) - longint'(a.v[0]); dx = d < 0 ? -d : d;
      d = longint'(b.v[1]) - longint'(a.v[1]); dy = d < 0 ? -d : d;
      sx = dx * dx;
      s = sx + dy * dy;
      // a wrapped sum is always beyond the threshold
      if (s < sx) return 1'b1;
      th = longint'(snap_th) * longint'(snap_th);
      return s > th;
    endfunction

    function void note_request(sib_in_t r);
      pose_rec_t s, a, b;
      longint latest, tgt, aus, bus;
      longint unsigned q;
      longint t;
      sib_out_t o;
      int k;
      if (r.command == CmdPush) begin
        s.tms = r.sample_time;
        s.v[0] = r.pos_x; s.v[1] = r.pos_y; s.v[2] = r.rotation;
        s.v[3] = r.lin_vel_x; s.v[4] = r.lin_vel_y; s.v[5] = r.ang_vel;
        if (count > 0) begin
          if (s.tms < ring[at(count - 1)].tms) return;
          if (s.tms == ring[at(count - 1)].tms) begin
            ring[at(count - 1)] = s;
            return;
          end
        end
        if (count >= Depth) begin
          oldest = (oldest + 1) % Depth;
          count = Depth - 1;
        end
        ring[at(count)] = s;
        count++;
        return;
      end
      if (authority) begin
        oldest = 0; count = 0; running = 0;
        return;
      end
      if (count == 0) return;
      latest = longint'(ring[at(count - 1)].tms) * 1000;
      tgt = latest - longint'(delay_ms) * 1000;
      if (!running) begin
        render_us = tgt;
        running = 1;
      end else begin
        render_us += longint'(r.tick_delta_us);
        if (render_us > latest) render_us = latest;
        if (render_us < tgt - 500000) render_us = tgt;
      end
      a = ring[at(0)];
      b = ring[at(count - 1)];
      if (render_us <= longint'(a.tms) * 1000) b = a;
      else if (render_us >= latest) a = b;
      else begin
        for (k = 0; k + 1 < count; k++) begin
          if (longint'(ring[at(k)].tms) * 1000 <= render_us &&
              render_us <= longint'(ring[at(k + 1)].tms) * 1000) begin
            a = ring[at(k)];
            b = ring[at(k + 1)];
            break;
          end
        end
      end
      aus = longint'(a.tms) * 1000;
      bus = longint'(b.tms) * 1000;
      t = 0;
      if (bus > aus && render_us - aus > 0) begin
        q = (longint'(render_us - aus) << 16) / longint'(bus - aus);
        t = q > 65536 ? 65536 : q;
      end
      if (snap_th > 0 && too_far(a, b)) t = 65536;
      o.out_pos_x = blend(a.v[0], b.v[0], t);
      o.out_pos_y = blend(a.v[1], b.v[1], t);
      o.out_rotation = blend(a.v[2], b.v[2], t);
      o.out_lin_vel_x = sync_vel ? blend(a.v[3], b.v[3], t) : '0;
      o.out_lin_vel_y = sync_vel ? blend(a.v[4], b.v[4], t) : '0;
      o.out_ang_vel = sync_vel ? blend(a.v[5], b.v[5], t) : '0;
      o.velocity_valid = sync_vel;
      pending_poses.insert(pending_poses.size(), o);
      while (count > 2 && longint'(ring[at(1)].tms) * 1000 <= render_us) begin
        oldest = (oldest + 1) % Depth;
        count--;
      end
    endfunction

    function void check_pose(sib_out_t got);
      sib_out_t e;
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending_poses[0];
      pending_poses.delete(0);
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("pose mismatch: expected %h got %h", e, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  sib_in_t in_data;
  sib_out_t out_data;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  pose_scoreboard sb;
  int idle_cycles;
  logic [31:0] now_ms;

  snapshot_interpolation_buffer_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  // receiver: stall on a shifting pattern with calm stretches
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_pose(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if ($urandom_range(0, 63) == 0) out_ready <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_ready <= ~out_ready;
  end

  always @(posedge clk) begin
    if (idle_cycles > WatchdogLimit) begin
      $display("[snapshot_interpolation_buffer_top] ERROR");
      $finish;
    end
  end

  // valid stays up after acceptance; callers drop it before any gap
  task automatic send_request(sib_in_t r);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    in_valid <= 1'b0;
    @(posedge clk);
    // hold until the block is idle and no result waits
    while (!in_ready || out_valid) @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_poses.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_val(int mode);
    case (mode)
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(0, 4000)) - 2000;
      default: return $urandom;
    endcase
  endfunction

  function automatic sib_in_t make_push(logic [31:0] tms, int mode);
    sib_in_t r;
    r.command = CmdPush;
    r.sample_time = tms;
    r.pos_x = rand_val(mode); r.pos_y = rand_val(mode); r.rotation = rand_val(mode);
    r.lin_vel_x = rand_val(mode); r.lin_vel_y = rand_val(mode); r.ang_vel = rand_val(mode);
    r.tick_delta_us = 20'($urandom);
    return r;
  endfunction

  function automatic sib_in_t make_tick(logic [19:0] dus);
    sib_in_t r;
    r = make_push($urandom, 3);
    r.command = CmdTick;
    r.tick_delta_us = dus;
    return r;
  endfunction

  task automatic random_phase(int n);
    int burst;
    int i;
    for (i = 0; i < n; i++) begin
      burst = $urandom_range(0, 7);
      if (burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      if ($urandom_range(0, 2) != 0) begin
        // mostly advancing timestamps, some duplicates and stale ones
        case ($urandom_range(0, 9))
          0: send_request(make_push(now_ms - $urandom_range(0, 200), $urandom_range(0, 3)));
          1: send_request(make_push(now_ms, $urandom_range(2, 3)));
          default: begin
            now_ms += $urandom_range(1, 60);
            send_request(make_push(now_ms, $urandom_range(0, 3)));
          end
        endcase
      end else begin
        case ($urandom_range(0, 5))
          0: send_request(make_tick(20'($urandom)));
          1: send_request(make_tick(20'd1000000));
          default: send_request(make_tick(20'($urandom_range(0, 40000))));
        endcase
      end
    end
  endtask

  initial begin
    int i;
    sb = new();
    sb.clear_all();
    rst_n = 0; in_valid = 0; in_data = '0; out_ready = 0;
    cfg_we = 0; cfg_idx = RegDelay; cfg_data = '0; idle_cycles = 0;
    now_ms = 1000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, first tick, extremes, stale, duplicate, outside range
    send_request(make_tick(20'd0));
    send_request(make_push(32'd1000, 0));
    send_request(make_tick(20'd500));
    send_request(make_push(32'd1050, 1));
    send_request(make_push(32'd1050, 2));
    send_request(make_push(32'd900, 3));
    send_request(make_push(32'd1100, 0));
    send_request(make_tick(20'd1000000));
    send_request(make_tick(20'd0));
    send_request(make_push(32'hFFFFFFFF, 1));
    send_request(make_tick(20'd1));
    drain();
    write_reg(RegAuthority, 31'd1);
    send_request(make_tick(20'd5));
    write_reg(RegAuthority, 31'd0);
    write_reg(RegSnap, 31'h7FFFFFFF);
    write_reg(RegSyncVel, 31'd0);
    write_reg(RegDelay, 31'd0);
    send_request(make_push(32'd0, 0));
    send_request(make_push(32'd10, 1));
    send_request(make_tick(20'd3));
    for (i = 0; i < 70; i++) send_request(make_push(32'd20 + i, 3));
    send_request(make_tick(20'd7));
    drain();

    write_reg(RegDelay, 31'd100);
    write_reg(RegSnap, 31'd0);
    write_reg(RegSyncVel, 31'd1);
    write_reg(RegAuthority, 31'd1);
    send_request(make_tick(20'd0));
    write_reg(RegAuthority, 31'd0);
    now_ms = 32'd5000;
    random_phase(500);
    drain();

    write_reg(RegSnap, 31'(32'd2000 << 16));
    write_reg(RegDelay, 31'd65535);
    write_reg(RegSyncVel, 31'd0);
    random_phase(400);
    drain();

    write_reg(RegDelay, 31'd0);
    write_reg(RegSnap, 31'd1);
    random_phase(400);
    drain();

    write_reg(RegDelay, 31'($urandom_range(20, 300)));
    write_reg(RegSnap, 31'd0);
    write_reg(RegSyncVel, 31'd1);
    write_reg(RegAuthority, 31'd0);
    random_phase(400);
    drain();

    if (sb.mismatches == 0 && sb.pending_poses.size() == 0)
      $display("[snapshot_interpolation_buffer_top] OK");
    else
      $display("[snapshot_interpolation_buffer_top] ERROR");
    $finish;
  end

endmodule
